[src/fcc_pkg.sv]
package fcc_pkg;

  localparam int FAT_ENTRIES_DEF = 4096;

  // table entry codes
  localparam logic [15:0] FAT_FREE    = 16'h0000;
  localparam logic [15:0] FAT_EOC     = 16'hFFFF;
  localparam logic [15:0] FAT_EOC_MIN = 16'hFFF8;
  localparam logic [15:0] FAT_MEDIA   = 16'hFFF8;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // operation codes
  localparam logic FUNC_RESOLVE = 1'b0;
  localparam logic FUNC_APPEND  = 1'b1;

  // configuration register indexes
  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_SHIFT = 1'b1;

  localparam logic [12:0] CFG_LIMIT_RST = 13'd4096;
  localparam logic [3:0]  CFG_SHIFT_RST = 4'd11;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_EOC,
    WR_LINK
  } wr_sel_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_SCAN,
    RD_WALK
  } rd_sel_t;

  typedef enum logic [1:0] {
    SCAN_HOLD,
    SCAN_INIT,
    SCAN_NEXT
  } scan_op_t;

  typedef enum logic [1:0] {
    WALK_HOLD,
    WALK_RES,
    WALK_APP,
    WALK_STEP
  } walk_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_FAIL,
    RES_FULL,
    RES_RESOLVE,
    RES_APPEND
  } res_sel_t;

  typedef struct packed {
    logic     load;
    wr_sel_t  wr_sel;
    rd_sel_t  rd_sel;
    scan_op_t scan_op;
    walk_op_t walk_op;
    res_sel_t res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic func;
    logic pre_ok;
    logic full_pre;
    logic first_zero;
    logic scan_hit;
    logic scan_last;
    logic cnt_zero;
    logic link_end;
  } dp_stat_t;

endpackage

[src/fcc_datapath.sv]
module fcc_datapath #(
  parameter int FAT_ENTRIES = fcc_pkg::FAT_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_func,
  input  logic [15:0]       in_first_cluster,
  input  logic [31:0]       in_byte_offset,
  input  logic [31:0]       in_file_size,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [12:0]       cfg_wdata,
  input  fcc_pkg::dp_cmd_t  cmd,
  output fcc_pkg::dp_stat_t st,
  output logic [1:0]        out_status,
  output logic [15:0]       out_cluster,
  output logic [14:0]       out_offset_in_cluster,
  output logic [15:0]       out_new_first_cluster
);

  localparam int          AW        = $clog2(FAT_ENTRIES);
  localparam logic [16:0] ENTRIES17 = 17'(FAT_ENTRIES);
  localparam logic [31:0] ENTRIES32 = 32'(FAT_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(FAT_ENTRIES - 1);

  logic [15:0] fat_mem [FAT_ENTRIES];

  logic [12:0]   cfg_limit_r;
  logic [3:0]    cfg_shift_r;
  logic [AW-1:0] clr_idx_r;

  logic          func_r;
  logic [15:0]   first_r;
  logic [31:0]   offset_r;
  logic [31:0]   size_r;
  logic [AW-1:0] scan_r;
  logic [15:0]   cur_r;
  logic [31:0]   cnt_r;
  logic          oor_r;
  logic [15:0]   rdata_r;

  logic [1:0]    res_status_r;
  logic [15:0]   res_cluster_r;
  logic [14:0]   res_inoff_r;
  logic [15:0]   res_newfirst_r;

  logic [16:0]   lim17;
  logic [16:0]   scan_nxt17;
  logic [15:0]   nxt16;
  logic          cur_in;
  logic [31:0]   links;
  logic [14:0]   inoff_mask;
  logic [15:0]   found16;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          rd_oor;

  assign lim17      = ({4'b0, cfg_limit_r} > ENTRIES17) ? ENTRIES17 : {4'b0, cfg_limit_r};
  assign scan_nxt17 = 17'(scan_r) + 17'd1;
  assign nxt16      = oor_r ? fcc_pkg::FAT_FREE : rdata_r;
  assign cur_in     = (17'(cur_r) < ENTRIES17);
  assign links      = offset_r >> cfg_shift_r;
  assign inoff_mask = 15'((17'd1 << cfg_shift_r) - 17'd1);
  assign found16    = 16'(scan_r);

  assign st.clr_last   = (clr_idx_r == LAST_IDX);
  assign st.func       = func_r;
  assign st.pre_ok     = (first_r != 16'd0) && (offset_r < size_r);
  assign st.full_pre   = (lim17 <= 17'd2);
  assign st.first_zero = (first_r == 16'd0);
  assign st.scan_hit   = (rdata_r == fcc_pkg::FAT_FREE);
  assign st.scan_last  = (scan_nxt17 >= lim17);
  assign st.cnt_zero   = (cnt_r == 32'd0);
  assign st.link_end   = (nxt16 == fcc_pkg::FAT_FREE) || (nxt16 >= fcc_pkg::FAT_EOC_MIN);

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx_r;
    wr_data = fcc_pkg::FAT_FREE;
    case (cmd.wr_sel)
      fcc_pkg::WR_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        if (clr_idx_r == AW'(0)) begin
          wr_data = fcc_pkg::FAT_MEDIA;
        end else if (clr_idx_r == AW'(1)) begin
          wr_data = fcc_pkg::FAT_EOC;
        end else begin
          wr_data = fcc_pkg::FAT_FREE;
        end
      end
      fcc_pkg::WR_EOC: begin
        wr_en   = 1'b1;
        wr_addr = scan_r;
        wr_data = fcc_pkg::FAT_EOC;
      end
      fcc_pkg::WR_LINK: begin
        // entries past the table drop the write
        wr_en   = cur_in;
        wr_addr = cur_r[AW-1:0];
        wr_data = found16;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // table read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_r;
    rd_oor  = 1'b0;
    case (cmd.rd_sel)
      fcc_pkg::RD_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_r;
      end
      fcc_pkg::RD_WALK: begin
        rd_en   = cur_in;
        rd_addr = cur_r[AW-1:0];
        rd_oor  = !cur_in;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fat_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= fat_mem[rd_addr];
    end
    if (cmd.rd_sel != fcc_pkg::RD_NONE) begin
      oor_r <= rd_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_limit_r <= fcc_pkg::CFG_LIMIT_RST;
      cfg_shift_r <= fcc_pkg::CFG_SHIFT_RST;
      clr_idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fcc_pkg::CFG_LIMIT: cfg_limit_r <= cfg_wdata;
          fcc_pkg::CFG_SHIFT: cfg_shift_r <= cfg_wdata[3:0];
          default: cfg_limit_r <= cfg_limit_r;
        endcase
      end
      if (cmd.wr_sel == fcc_pkg::WR_CLEAR) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      first_r  <= in_first_cluster;
      offset_r <= in_byte_offset;
      size_r   <= in_file_size;
    end

    case (cmd.scan_op)
      fcc_pkg::SCAN_INIT: scan_r <= AW'(2);
      fcc_pkg::SCAN_NEXT: scan_r <= scan_r + AW'(1);
      default:            scan_r <= scan_r;
    endcase

    case (cmd.walk_op)
      fcc_pkg::WALK_RES: begin
        cur_r <= first_r;
        cnt_r <= links;
      end
      fcc_pkg::WALK_APP: begin
        cur_r <= first_r;
        cnt_r <= ENTRIES32;
      end
      fcc_pkg::WALK_STEP: begin
        cur_r <= nxt16;
        cnt_r <= cnt_r - 32'd1;
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase

    case (cmd.res_sel)
      fcc_pkg::RES_FAIL: begin
        res_status_r   <= fcc_pkg::ST_BAD;
        res_cluster_r  <= 16'd0;
        res_inoff_r    <= 15'd0;
        res_newfirst_r <= first_r;
      end
      fcc_pkg::RES_FULL: begin
        res_status_r   <= fcc_pkg::ST_FULL;
        res_cluster_r  <= 16'd0;
        res_inoff_r    <= 15'd0;
        res_newfirst_r <= first_r;
      end
      fcc_pkg::RES_RESOLVE: begin
        res_status_r   <= fcc_pkg::ST_OK;
        res_cluster_r  <= cur_r;
        res_inoff_r    <= offset_r[14:0] & inoff_mask;
        res_newfirst_r <= first_r;
      end
      fcc_pkg::RES_APPEND: begin
        res_status_r   <= fcc_pkg::ST_OK;
        res_cluster_r  <= found16;
        res_inoff_r    <= 15'd0;
        res_newfirst_r <= (first_r == 16'd0) ? found16 : first_r;
      end
      default: begin
        res_status_r <= res_status_r;
      end
    endcase

    if (cmd.out_load) begin
      out_status            <= res_status_r;
      out_cluster           <= res_cluster_r;
      out_offset_in_cluster <= res_inoff_r;
      out_new_first_cluster <= res_newfirst_r;
    end
  end

endmodule

[src/fcc_ctrl.sv]
module fcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fcc_pkg::dp_stat_t st,
  output fcc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_WALK_RD,
    S_WALK_EV,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.load      = 1'b0;
    cmd.wr_sel    = fcc_pkg::WR_NONE;
    cmd.rd_sel    = fcc_pkg::RD_NONE;
    cmd.scan_op   = fcc_pkg::SCAN_HOLD;
    cmd.walk_op   = fcc_pkg::WALK_HOLD;
    cmd.res_sel   = fcc_pkg::RES_NONE;
    cmd.out_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_sel = fcc_pkg::WR_CLEAR;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.func == fcc_pkg::FUNC_RESOLVE) begin
          if (st.pre_ok) begin
            cmd.walk_op = fcc_pkg::WALK_RES;
            state_nxt   = S_WALK_RD;
          end else begin
            cmd.res_sel = fcc_pkg::RES_FAIL;
            state_nxt   = S_DONE;
          end
        end else if (st.full_pre) begin
          cmd.res_sel = fcc_pkg::RES_FULL;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_op = fcc_pkg::SCAN_INIT;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_sel = fcc_pkg::RD_SCAN;
        state_nxt  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (st.scan_hit) begin
          // mark end of chain before the tail search
          cmd.wr_sel = fcc_pkg::WR_EOC;
          if (st.first_zero) begin
            cmd.res_sel = fcc_pkg::RES_APPEND;
            state_nxt   = S_DONE;
          end else begin
            cmd.walk_op = fcc_pkg::WALK_APP;
            state_nxt   = S_WALK_RD;
          end
        end else if (st.scan_last) begin
          cmd.res_sel = fcc_pkg::RES_FULL;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_op = fcc_pkg::SCAN_NEXT;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_WALK_RD: begin
        if (st.cnt_zero) begin
          if (st.func == fcc_pkg::FUNC_APPEND) begin
            cmd.wr_sel  = fcc_pkg::WR_LINK;
            cmd.res_sel = fcc_pkg::RES_APPEND;
          end else begin
            cmd.res_sel = fcc_pkg::RES_RESOLVE;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.rd_sel = fcc_pkg::RD_WALK;
          state_nxt  = S_WALK_EV;
        end
      end
      S_WALK_EV: begin
        if (st.link_end) begin
          if (st.func == fcc_pkg::FUNC_APPEND) begin
            cmd.wr_sel  = fcc_pkg::WR_LINK;
            cmd.res_sel = fcc_pkg::RES_APPEND;
          end else begin
            cmd.res_sel = fcc_pkg::RES_FAIL;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.walk_op = fcc_pkg::WALK_STEP;
          state_nxt   = S_WALK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= (state_nxt != S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/fat_cluster_chain_engine.sv]
// fat16 cluster chain engine: keeps a fat16 allocation table of FAT_ENTRIES 16-bit entries
// in one single-port-read / single-port-write memory and runs one operation per input beat.
// resolve (func 0) walks byte_offset >> cluster_shift links from first_cluster and returns the
// cluster reached and the offset inside it; status 1 if the file has no chain, the offset is
// at or past file_size, or a link ends the chain early. append (func 1) takes the lowest free
// entry from cluster 2 below min(cluster_limit, FAT_ENTRIES), marks it end-of-chain and links
// it behind the chain's tail (or returns it as new_first_cluster for an empty file); status 2
// and no table change when no entry is free. after reset the block runs a clearing pass over
// all FAT_ENTRIES entries (entry 0 gets the media code, entry 1 end-of-chain, the rest free) and
// holds in_stall high until it finishes; configuration writes are taken at any time. every
// table read is registered, so each link followed and each entry scanned takes a read state and
// an evaluate state. one item is worked on at a time; the result sits in an output register so
// the next beat can be taken while it waits.
module fat_cluster_chain_engine #(
  parameter int FAT_ENTRIES = fcc_pkg::FAT_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [15:0] in_first_cluster,
  input  logic [31:0] in_byte_offset,
  input  logic [31:0] in_file_size,

  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_cluster,
  output logic [14:0] out_offset_in_cluster,
  output logic [15:0] out_new_first_cluster,

  // configuration: index 0 cluster_limit, index 1 cluster_shift
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_wdata
);

  // command and status between the sequencer and the table datapath
  fcc_pkg::dp_cmd_t  cmd;
  fcc_pkg::dp_stat_t st;

  // sequencer: clearing pass, decode, free-entry scan, chain walk, result hand-off
  fcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: table memory, config registers, scan/walk counters, result registers
  fcc_datapath #(
    .FAT_ENTRIES (FAT_ENTRIES)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_func               (in_func),
    .in_first_cluster      (in_first_cluster),
    .in_byte_offset        (in_byte_offset),
    .in_file_size          (in_file_size),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .cmd                   (cmd),
    .st                    (st),
    .out_status            (out_status),
    .out_cluster           (out_cluster),
    .out_offset_in_cluster (out_offset_in_cluster),
    .out_new_first_cluster (out_new_first_cluster)
  );

endmodule

[tb/fat_cluster_chain_engine_tb.sv]
`timescale 1ns / 1ps

module fat_cluster_chain_engine_tb;

  localparam int FAT_N = fcc_pkg::FAT_ENTRIES_DEF;
  localparam int TB_AW = $clog2(FAT_N);
  localparam int RANDOM_PHASES = 11;
  localparam int BEATS_PER_PHASE = 50;
  localparam int HOLD_CYCLES = 400;
  localparam longint TIMEOUT_NS = 80_000_000;

  // one input beat and one result beat, at the port widths
  typedef struct packed {
    logic        func;
    logic [15:0] first;
    logic [31:0] offset;
    logic [31:0] size;
  } op_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cluster;
    logic [14:0] inoff;
    logic [15:0] new_first;
  } chain_res_t;

  // directed table: either a beat (optionally with a typed-in result) or a register write
  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    op_beat_t    beat;
    logic        has_want;
    chain_res_t  want;
    logic        reg_idx;
    logic [12:0] reg_val;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [15:0] in_first_cluster;
  logic [31:0] in_byte_offset;
  logic [31:0] in_file_size;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_cluster;
  logic [14:0] out_offset_in_cluster;
  logic [15:0] out_new_first_cluster;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_wdata;

  // mirror of the allocation table and the two registers
  logic [15:0] table_mirror [0:FAT_N-1];
  logic [12:0] lim_mirror;
  logic [3:0]  shift_mirror;

  chain_res_t  due_results[$];
  chain_res_t  last_outcome;
  logic [15:0] chain_heads[$];
  stim_row_t   dir_rows[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  logic        hold_off_req = 1'b0;

  fat_cluster_chain_engine #(
    .FAT_ENTRIES(FAT_N)
  ) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_func               (in_func),
    .in_first_cluster      (in_first_cluster),
    .in_byte_offset        (in_byte_offset),
    .in_file_size          (in_file_size),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_cluster           (out_cluster),
    .out_offset_in_cluster (out_offset_in_cluster),
    .out_new_first_cluster (out_new_first_cluster),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // safety net against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- table mirror

  // clusters past the table read as free
  function automatic logic [15:0] mirror_rd(input logic [31:0] idx);
    if (idx >= FAT_N) return fcc_pkg::FAT_FREE;
    return table_mirror[idx[TB_AW-1:0]];
  endfunction

  // and writes past the table are dropped
  function automatic void mirror_wr(input logic [31:0] idx, input logic [15:0] val);
    if (idx < FAT_N) table_mirror[idx[TB_AW-1:0]] = val;
  endfunction

  // free or any end-of-chain code stops a walk
  function automatic logic link_ends(input logic [15:0] v);
    return (v == fcc_pkg::FAT_FREE) || (v >= fcc_pkg::FAT_EOC_MIN);
  endfunction

  // lowest free entry from 2 below the limit, 0 when the disk is full
  function automatic logic [15:0] lowest_free();
    int lim;
    lim = (lim_mirror > FAT_N) ? FAT_N : lim_mirror;
    for (int c = 2; c < lim; c++)
      if (table_mirror[TB_AW'(c)] == fcc_pkg::FAT_FREE) return 16'(c);
    return 16'd0;
  endfunction

  // result of one operation, applying its table writes to the mirror
  function automatic chain_res_t compute_chain_op(input op_beat_t b);
    chain_res_t  r;
    logic [31:0] links;
    logic [31:0] cur;
    logic [31:0] steps;
    logic [31:0] mask;
    logic [31:0] low;
    logic [15:0] nxt;
    logic [15:0] found;
    logic        ok;
    r.status    = fcc_pkg::ST_BAD;
    r.cluster   = 16'd0;
    r.inoff     = 15'd0;
    r.new_first = b.first;
    if (b.func == fcc_pkg::FUNC_RESOLVE) begin
      if (b.first != 16'd0 && b.offset < b.size) begin
        links = b.offset >> shift_mirror;
        cur   = 32'(b.first);
        ok    = 1'b1;
        // exact link count, so a cyclic chain is walked round and round
        while (links != 0) begin
          nxt = mirror_rd(cur);
          if (link_ends(nxt)) begin
            ok = 1'b0;
            break;
          end
          cur = 32'(nxt);
          links--;
        end
        if (ok) begin
          mask      = (32'd1 << shift_mirror) - 32'd1;
          low       = b.offset & mask;
          r.status  = fcc_pkg::ST_OK;
          r.cluster = cur[15:0];
          r.inoff   = low[14:0];
        end
      end
    end else begin
      found = lowest_free();
      if (found == 16'd0) begin
        r.status = fcc_pkg::ST_FULL;
      end else begin
        // marked end-of-chain before the tail search sees it
        mirror_wr(32'(found), fcc_pkg::FAT_EOC);
        if (b.first == 16'd0) begin
          r.new_first = found;
        end else begin
          cur   = 32'(b.first);
          steps = 32'd0;
          // tail search gives up after one pass over the table
          while (steps < FAT_N) begin
            nxt = mirror_rd(cur);
            if (link_ends(nxt)) break;
            cur = 32'(nxt);
            steps++;
          end
          mirror_wr(cur, found);
        end
        r.status  = fcc_pkg::ST_OK;
        r.cluster = found;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- directed rows

  function automatic stim_row_t beat_row(input logic f, input logic [15:0] fc,
                                         input logic [31:0] off, input logic [31:0] sz);
    stim_row_t r;
    r             = '0;
    r.kind        = ROW_BEAT;
    r.beat.func   = f;
    r.beat.first  = fc;
    r.beat.offset = off;
    r.beat.size   = sz;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic f, input logic [15:0] fc,
                                            input logic [31:0] off, input logic [31:0] sz,
                                            input logic [1:0] st, input logic [15:0] cl,
                                            input logic [14:0] io, input logic [15:0] nf);
    stim_row_t r;
    r          = beat_row(f, fc, off, sz);
    r.has_want = 1'b1;
    r.want     = {st, cl, io, nf};
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic idx, input logic [12:0] val);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // burst / gap pacing of the input side
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // offer one beat, hold it until taken, then queue what it should produce
  task automatic send_beat(input op_beat_t b, input logic has_want, input chain_res_t want);
    chain_res_t pred;
    @(negedge clk);
    in_valid         <= 1'b1;
    in_func          <= b.func;
    in_first_cluster <= b.first;
    in_byte_offset   <= b.offset;
    in_file_size     <= b.size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = compute_chain_op(b);
    due_results.push_back(has_want ? want : pred);
    last_outcome = pred;
  endtask

  // stop offering and let every queued result come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fcc_pkg::CFG_LIMIT) lim_mirror = val;
    else shift_mirror = val[3:0];
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern: modes of random length, from never stalling to mostly stalling,
  // plus one long hold-off on request so the block backs up into its input
  initial begin : receiver
    int pat_cnt;
    int pat_mode;
    pat_cnt   = 0;
    pat_mode  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (pat_cnt == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_cnt  = $urandom_range(20, 120);
        end
        pat_cnt--;
        case (pat_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- result check

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    chain_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got status %0d cluster 0x%0h",
                 $time, out_status, out_cluster);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("cluster", want.cluster, out_cluster);
        check_field("offset_in_cluster", 16'(want.inoff), 16'(out_offset_in_cluster));
        check_field("new_first_cluster", want.new_first, out_new_first_cluster);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    op_beat_t    b;
    logic [31:0] links;
    logic [31:0] mask;
    logic [12:0] lim_pick;
    logic [3:0]  shift_pick;
    int          phase;
    int          k;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = fcc_pkg::FUNC_RESOLVE;
    in_first_cluster = 16'd0;
    in_byte_offset   = 32'd0;
    in_file_size     = 32'd0;
    cfg_we           = 1'b0;
    cfg_index        = fcc_pkg::CFG_LIMIT;
    cfg_wdata        = 13'd0;

    // table after reset: media code, reserved end-of-chain, the rest free
    table_mirror    = '{default: fcc_pkg::FAT_FREE};
    table_mirror[0] = fcc_pkg::FAT_MEDIA;
    table_mirror[1] = fcc_pkg::FAT_EOC;
    lim_mirror   = fcc_pkg::CFG_LIMIT_RST;
    shift_mirror = fcc_pkg::CFG_SHIFT_RST;

    // no chain, offset at end, zero links from a free entry, link off a free entry
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_RESOLVE, 16'd0, 32'd0, 32'd0,
                                   fcc_pkg::ST_BAD, 16'd0, 15'd0, 16'd0));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_RESOLVE, 16'd5, 32'd0, 32'd0,
                                   fcc_pkg::ST_BAD, 16'd0, 15'd0, 16'd5));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_RESOLVE, 16'd2, 32'd100, 32'd4096,
                                   fcc_pkg::ST_OK, 16'd2, 15'd100, 16'd2));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_RESOLVE, 16'd2, 32'd2048, 32'hFFFF_FFFF,
                                   fcc_pkg::ST_BAD, 16'd0, 15'd0, 16'd2));
    // build 2 -> 3 -> 4 from an empty file
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_APPEND, 16'd0, 32'd0, 32'd0,
                                   fcc_pkg::ST_OK, 16'd2, 15'd0, 16'd2));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_APPEND, 16'd2, 32'd0, 32'd0,
                                   fcc_pkg::ST_OK, 16'd3, 15'd0, 16'd2));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_APPEND, 16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   fcc_pkg::ST_OK, 16'd4, 15'd0, 16'd2));
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_RESOLVE, 16'd2, 32'd4103, 32'hFFFF_FFFF));
    // chain ends one link short
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_RESOLVE, 16'd2, 32'd6144, 32'hFFFF_FFFF));
    // clusters past the table
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_RESOLVE, 16'hFFFF, 32'd0, 32'd1,
                                   fcc_pkg::ST_OK, 16'hFFFF, 15'd0, 16'hFFFF));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_RESOLVE, 16'hFFFF, 32'hFFFF_FFFE,
                                   32'hFFFF_FFFF,
                                   fcc_pkg::ST_BAD, 16'd0, 15'd0, 16'hFFFF));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_APPEND, 16'hFFFF, 32'd0, 32'd0,
                                   fcc_pkg::ST_OK, 16'd5, 15'd0, 16'hFFFF));
    // append behind the reserved entry, then walk through it
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_APPEND, 16'd1, 32'd0, 32'd0));
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_RESOLVE, 16'd1, 32'd2053, 32'h0010_0000));
    // append onto the free entry that gets allocated: links to itself
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_APPEND, 16'd7, 32'd0, 32'd0));
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_RESOLVE, 16'd7, 32'd10243, 32'hFFFF_FFFF));
    // tail search round the loop gives up, which breaks the loop
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_APPEND, 16'd7, 32'd0, 32'd0));
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_RESOLVE, 16'd7, 32'd2048, 32'hFFFF_FFFF));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_RESOLVE, 16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   fcc_pkg::ST_BAD, 16'd0, 15'd0, 16'd2));
    // smallest limit that allows anything: still full here
    dir_rows.push_back(reg_row(fcc_pkg::CFG_LIMIT, 13'd3));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_APPEND, 16'd2, 32'd0, 32'd0,
                                   fcc_pkg::ST_FULL, 16'd0, 15'd0, 16'd2));
    dir_rows.push_back(reg_row(fcc_pkg::CFG_LIMIT, 13'd0));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_APPEND, 16'd0, 32'd0, 32'd0,
                                   fcc_pkg::ST_FULL, 16'd0, 15'd0, 16'd0));
    // limit past the table, largest cluster size
    dir_rows.push_back(reg_row(fcc_pkg::CFG_LIMIT, 13'h1FFF));
    dir_rows.push_back(reg_row(fcc_pkg::CFG_SHIFT, 13'd15));
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_APPEND, 16'd0, 32'd0, 32'd0));
    dir_rows.push_back(checked_row(fcc_pkg::FUNC_RESOLVE, 16'd2, 32'h7FFF, 32'hFFFF_FFFF,
                                   fcc_pkg::ST_OK, 16'd2, 15'h7FFF, 16'd2));
    // shift below the usual range: one-byte clusters
    dir_rows.push_back(reg_row(fcc_pkg::CFG_SHIFT, 13'd0));
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_RESOLVE, 16'd2, 32'd1, 32'd2));
    dir_rows.push_back(beat_row(fcc_pkg::FUNC_RESOLVE, 16'd2, 32'd2, 32'd3));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part; the first beat waits out the clearing pass on in_stall
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        pace();
        send_beat(dir_rows[i].beat, dir_rows[i].has_want, dir_rows[i].want);
      end
    end

    // random part, one register setting per phase
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case ($urandom_range(0, 9))
        0: lim_pick = 13'($urandom_range(0, 2));
        1: lim_pick = 13'd4096;
        2: lim_pick = 13'($urandom_range(4097, 8191));
        default: lim_pick = 13'($urandom_range(3, 600));
      endcase
      shift_pick = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 8)) :
                                                 4'($urandom_range(9, 15));
      write_reg(fcc_pkg::CFG_LIMIT, lim_pick);
      write_reg(fcc_pkg::CFG_SHIFT, {9'd0, shift_pick});

      // long receiver hold-off while beats keep coming
      if (phase == 2) begin
        @(posedge clk);
        hold_off_req = 1'b1;
      end

      for (k = 0; k < BEATS_PER_PHASE; k++) begin
        // sender pauses until everything in flight has come out
        if (phase == 5 && k == BEATS_PER_PHASE / 2) drain();

        b.func = $urandom_range(0, 1) ? fcc_pkg::FUNC_APPEND : fcc_pkg::FUNC_RESOLVE;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5:
            b.first = (chain_heads.size() != 0) ?
                      chain_heads[$urandom_range(0, chain_heads.size() - 1)] : 16'd0;
          6: b.first = 16'd0;
          7: b.first = 16'($urandom_range(0, 15));
          8: b.first = 16'($urandom_range(0, 65535));
          default: b.first = 16'($urandom_range(2, 700));
        endcase
        // appending onto the entry about to be allocated would leave a self loop
        if (b.func == fcc_pkg::FUNC_APPEND && b.first != 16'd0 && b.first == lowest_free())
          b.first = 16'd0;

        mask = (32'd1 << shift_mirror) - 32'd1;
        case ($urandom_range(0, 7))
          6: b.offset = $urandom;
          7: b.offset = 32'd0;
          default: begin
            links    = $urandom_range(0, 24);
            b.offset = (links << shift_mirror) | ($urandom & mask);
          end
        endcase
        case ($urandom_range(0, 8))
          6: b.size = $urandom;
          7: b.size = b.offset;
          8: b.size = 32'hFFFF_FFFF;
          default: b.size = b.offset + $urandom_range(1, 5000);
        endcase

        pace();
        send_beat(b, 1'b0, '0);

        // new files become chain heads for later beats
        if (b.func == fcc_pkg::FUNC_APPEND && b.first == 16'd0 &&
            last_outcome.status == fcc_pkg::ST_OK) begin
          if (chain_heads.size() >= 24)
            chain_heads[$urandom_range(0, 23)] = last_outcome.new_first;
          else
            chain_heads.push_back(last_outcome.new_first);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
src/fcc_pkg.sv
src/fcc_datapath.sv
src/fcc_ctrl.sv
src/fat_cluster_chain_engine.sv
tb/fat_cluster_chain_engine_tb.sv
